// File: hdl/nns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest neighbor search package
// Shared sizes, codes and types for the brute-force nearest neighbor search.
// ----------------------------------------------------------------------------
package nns_pkg;

    localparam int ENTRIES = 64;
    localparam int DIM     = 3;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam int COORD_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int DIFF_W   = 17;
    localparam int SQ_W     = 32;
    localparam int DSQ_W    = 34;
    localparam int OUT_IDX_W = 6;

    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] coord;
        logic [VALUE_W-1:0]      value;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
    } dist_tag_t;

    function automatic logic [OUT_IDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] i);
        logic [IDX_W+OUT_IDX_W-1:0] w;
        w = {{OUT_IDX_W{1'b0}}, i};
        return w[OUT_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/nns_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest neighbor search storage cell
// Holds one table entry; during a scan it takes the entry of its neighbor.
// ----------------------------------------------------------------------------
module nns_cell (
    input  wire logic               aclk,
    input  wire logic               shift_en,
    input  wire logic               load_en,
    input  wire nns_pkg::entry_t    load_entry,
    input  wire nns_pkg::entry_t    nbr_entry,
    output nns_pkg::entry_t         entry_q
);

    nns_pkg::entry_t entry_reg;
    nns_pkg::entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (shift_en) begin
            entry_next = nbr_entry;
        end else if (load_en) begin
            entry_next = load_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule
`default_nettype wire

// File: hdl/nns_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest neighbor search distance unit
// Three-stage pipeline: coordinate differences, squares, sum of squares.
// ----------------------------------------------------------------------------
module nns_dist (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire nns_pkg::dist_tag_t                in_tag,
    input  wire logic [2:0][nns_pkg::COORD_W-1:0]  query,
    input  wire logic [2:0][nns_pkg::COORD_W-1:0]  point,
    output nns_pkg::dist_tag_t                     out_tag,
    output logic [nns_pkg::DSQ_W-1:0]              out_dsq,
    output logic                                   busy
);

    nns_pkg::dist_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic signed [nns_pkg::DIFF_W-1:0] diff_reg [3];
    logic signed [nns_pkg::DIFF_W-1:0] diff_next [3];
    logic [nns_pkg::SQ_W-1:0] sq_reg [3];
    logic [nns_pkg::SQ_W-1:0] sq_next [3];
    logic [nns_pkg::DSQ_W-1:0] dsq_reg;
    logic [nns_pkg::DSQ_W-1:0] dsq_next;

    always_comb begin
        logic signed [nns_pkg::DIFF_W-1:0] a;
        logic signed [nns_pkg::DIFF_W-1:0] b;
        logic signed [2*nns_pkg::DIFF_W-1:0] p;
        for (int k = 0; k < 3; k++) begin
            a = {query[k][nns_pkg::COORD_W-1], query[k]};
            b = {point[k][nns_pkg::COORD_W-1], point[k]};
            diff_next[k] = (k < nns_pkg::DIM) ? (a - b) : '0;
            p = diff_reg[k] * diff_reg[k];
            sq_next[k] = p[nns_pkg::SQ_W-1:0];
        end
        dsq_next = {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
            tag3_reg.valid <= 1'b0;
        end else begin
            tag1_reg.valid <= in_tag.valid;
            tag2_reg.valid <= tag1_reg.valid;
            tag3_reg.valid <= tag2_reg.valid;
        end
        tag1_reg.idx   <= in_tag.idx;
        tag1_reg.value <= in_tag.value;
        tag2_reg.idx   <= tag1_reg.idx;
        tag2_reg.value <= tag1_reg.value;
        tag3_reg.idx   <= tag2_reg.idx;
        tag3_reg.value <= tag2_reg.value;
        for (int k = 0; k < 3; k++) begin
            diff_reg[k] <= diff_next[k];
            sq_reg[k]   <= sq_next[k];
        end
        dsq_reg <= dsq_next;
    end

    assign out_tag = tag3_reg;
    assign out_dsq = dsq_reg;
    assign busy    = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

endmodule
`default_nettype wire

// File: hdl/nearest_neighbor_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest neighbor search
// Brute-force search of a table of points for the entry nearest to a query.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_       in         func, coord0..coord2, entry_value
//  m_       out        status, found_value, found_index, distance_sq
//
//  Clear, append and unknown beats are answered in the cycle after accept.
//  A query rotates the ring of ENTRIES cells once, one entry past the distance
//  unit per cycle, then drains its three-stage pipeline.
//  Reset clears the entry count and control; cell contents stay undefined.
//  A stalled result holds the block; the next beat is taken as it drains.
// ----------------------------------------------------------------------------
module nearest_neighbor_search (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_func,
    input  wire logic signed [15:0]  s_coord0,
    input  wire logic signed [15:0]  s_coord1,
    input  wire logic signed [15:0]  s_coord2,
    input  wire logic [31:0]         s_entry_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [31:0]              m_found_value,
    output logic [5:0]               m_found_index,
    output logic [33:0]              m_distance_sq
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    localparam int E  = nns_pkg::ENTRIES;
    localparam int IW = nns_pkg::IDX_W;
    localparam int CW = nns_pkg::CNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(E - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(E);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [2:0][nns_pkg::COORD_W-1:0] q_reg, q_next;

    logic                        have_reg, have_next;
    logic                        stop_reg, stop_next;
    logic [nns_pkg::DSQ_W-1:0]   best_d_reg, best_d_next;
    logic [IW-1:0]               best_i_reg, best_i_next;
    logic [nns_pkg::VALUE_W-1:0] best_v_reg, best_v_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] fval_reg, fval_next;
    logic [5:0]  fidx_reg, fidx_next;
    logic [33:0] dsq_reg, dsq_next;

    nns_pkg::entry_t    cell_q [E];
    nns_pkg::entry_t    load_entry;
    nns_pkg::dist_tag_t feed_tag;
    nns_pkg::dist_tag_t res_tag;
    logic [nns_pkg::DSQ_W-1:0] res_dsq;
    logic dist_busy;
    logic shift_en;
    logic append_ok;
    logic accept;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign shift_en = (state_reg == S_SCAN);
    assign append_ok = accept && (s_func == nns_pkg::FN_APPEND) && (count_reg < FULL_CNT);

    assign load_entry.coord[0] = s_coord0;
    assign load_entry.coord[1] = s_coord1;
    assign load_entry.coord[2] = s_coord2;
    assign load_entry.value    = s_entry_value;

    for (genvar i = 0; i < E; i++) begin : g_cell
        nns_cell u_cell (
            .aclk       (aclk),
            .shift_en   (shift_en),
            .load_en    (append_ok && (count_reg[IW-1:0] == IW'(i))),
            .load_entry (load_entry),
            .nbr_entry  (cell_q[(i + 1) % E]),
            .entry_q    (cell_q[i])
        );
    end

    assign feed_tag.valid = shift_en && ({{(CW - IW + 1){1'b0}}, scan_reg} <
                                         {1'b0, count_reg});
    assign feed_tag.idx   = scan_reg;
    assign feed_tag.value = cell_q[0].value;

    nns_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (feed_tag),
        .query   (q_reg),
        .point   (cell_q[0].coord),
        .out_tag (res_tag),
        .out_dsq (res_dsq),
        .busy    (dist_busy)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        q_next       = q_reg;
        have_next    = have_reg;
        stop_next    = stop_reg;
        best_d_next  = best_d_reg;
        best_i_next  = best_i_reg;
        best_v_next  = best_v_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        fval_next    = fval_reg;
        fidx_next    = fidx_reg;
        dsq_next     = dsq_reg;

        if (res_tag.valid && !stop_reg) begin
            if (!have_reg || (res_dsq < best_d_reg)) begin
                have_next   = 1'b1;
                best_d_next = res_dsq;
                best_i_next = res_tag.idx;
                best_v_next = res_tag.value;
            end else if (res_dsq == '0) begin
                stop_next   = 1'b1;
                best_i_next = res_tag.idx;
                best_v_next = res_tag.value;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = nns_pkg::ST_OK;
                    fval_next   = '0;
                    fidx_next   = '0;
                    dsq_next    = '0;
                    if (s_func == nns_pkg::FN_CLEAR) begin
                        count_next   = '0;
                        m_valid_next = 1'b1;
                    end else if (s_func == nns_pkg::FN_APPEND) begin
                        m_valid_next = 1'b1;
                        if (count_reg < FULL_CNT) begin
                            fidx_next  = nns_pkg::idx_to_out(count_reg[IW-1:0]);
                            count_next = count_reg + 1'b1;
                        end else begin
                            status_next = nns_pkg::ST_FULL;
                        end
                    end else if (s_func == nns_pkg::FN_QUERY) begin
                        if (count_reg == '0) begin
                            status_next  = nns_pkg::ST_EMPTY;
                            m_valid_next = 1'b1;
                        end else begin
                            q_next[0]  = s_coord0;
                            q_next[1]  = s_coord1;
                            q_next[2]  = s_coord2;
                            scan_next  = '0;
                            have_next  = 1'b0;
                            stop_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == LAST_IDX) begin
                    scan_next  = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!dist_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    status_next  = nns_pkg::ST_OK;
                    fval_next    = best_v_reg;
                    fidx_next    = nns_pkg::idx_to_out(best_i_reg);
                    dsq_next     = best_d_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            have_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            have_reg    <= have_next;
            stop_reg    <= stop_next;
            m_valid_reg <= m_valid_next;
        end
        q_reg      <= q_next;
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        best_v_reg <= best_v_next;
        status_reg <= status_next;
        fval_reg   <= fval_next;
        fidx_reg   <= fidx_next;
        dsq_reg    <= dsq_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found_value = fval_reg;
    assign m_found_index = fidx_reg;
    assign m_distance_sq = dsq_reg;

endmodule
`default_nettype wire

// File: sim/tb_nearest_neighbor_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for nearest_neighbor_search
// Sends clear, append, query and unused beats with random gaps and result
// stalls, predicts every result from a shadow copy of the point table and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_search;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1450;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = nns_pkg::ENTRIES + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [1:0]                       func;
        logic [2:0][nns_pkg::COORD_W-1:0] coord;
        logic [nns_pkg::VALUE_W-1:0]      value;
        int                               gap;
    } nn_beat_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [nns_pkg::VALUE_W-1:0]   value;
        logic [nns_pkg::OUT_IDX_W-1:0] index;
        logic [nns_pkg::DSQ_W-1:0]     dsq;
    } nn_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_func = nns_pkg::FN_CLEAR;
    logic signed [15:0]    s_coord0 = '0;
    logic signed [15:0]    s_coord1 = '0;
    logic signed [15:0]    s_coord2 = '0;
    logic [31:0]           s_entry_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_status;
    logic [31:0]           m_found_value;
    logic [5:0]            m_found_index;
    logic [33:0]           m_distance_sq;

    logic                  hold_off = 1'b0;

    nn_beat_t              pending_beats[$];
    nn_result_t            pending_results[$];

    logic [2:0][nns_pkg::COORD_W-1:0] stored_points [nns_pkg::ENTRIES];
    logic [nns_pkg::VALUE_W-1:0]      stored_values [nns_pkg::ENTRIES];
    int                               stored_count = 0;

    logic [2:0][nns_pkg::COORD_W-1:0] gen_points [nns_pkg::ENTRIES];
    int                      gen_count = 0;
    int                      gen_burst = 0;
    int                      stimulus_beats = 0;
    int                      total_beats = 0;

    int                      beats_accepted = 0;
    int                      results_checked = 0;
    int                      failures = 0;
    int                      cycles = 0;
    int                      n_clears = 0;
    int                      n_appends = 0;
    int                      n_full = 0;
    int                      n_found = 0;
    int                      n_later_zero = 0;
    int                      n_empty = 0;
    int                      n_unused = 0;

    nearest_neighbor_search DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_coord0      (s_coord0),
        .s_coord1      (s_coord1),
        .s_coord2      (s_coord2),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_found_index (m_found_index),
        .m_distance_sq (m_distance_sq)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending.", cycles,
                     pending_results.size());
            $display("tb_nearest_neighbor_search NOT OK");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycles, msg);
        failures++;
    endtask

    function automatic logic [nns_pkg::DSQ_W-1:0] squared_distance(
        input logic [2:0][nns_pkg::COORD_W-1:0] a,
        input logic [2:0][nns_pkg::COORD_W-1:0] b
    );
        longint sum;
        longint d;
        sum = 0;
        for (int k = 0; k < nns_pkg::DIM; k++) begin
            d = longint'($signed(a[k])) - longint'($signed(b[k]));
            sum += d * d;
        end
        return sum[nns_pkg::DSQ_W-1:0];
    endfunction

    function automatic nn_result_t search_nearest(input nn_beat_t b);
        nn_result_t r;
        logic [nns_pkg::DSQ_W-1:0] d;
        logic [nns_pkg::DSQ_W-1:0] best_d;
        int best;
        bit have;
        r = '0;
        case (b.func)
            nns_pkg::FN_CLEAR: begin
                stored_count = 0;
                n_clears++;
            end
            nns_pkg::FN_APPEND: begin
                if (stored_count >= nns_pkg::ENTRIES) begin
                    r.status = nns_pkg::ST_FULL;
                    n_full++;
                end else begin
                    stored_points[stored_count] = b.coord;
                    stored_values[stored_count] = b.value;
                    r.index = stored_count[nns_pkg::OUT_IDX_W-1:0];
                    stored_count++;
                    n_appends++;
                end
            end
            nns_pkg::FN_QUERY: begin
                if (stored_count == 0) begin
                    r.status = nns_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    have = 1'b0;
                    best = 0;
                    best_d = '0;
                    for (int i = 0; i < stored_count; i++) begin
                        d = squared_distance(b.coord, stored_points[i]);
                        if (!have || d < best_d) begin
                            have = 1'b1;
                            best_d = d;
                            best = i;
                        end else if (d == 0) begin
                            best = i;
                            n_later_zero++;
                            break;
                        end
                    end
                    r.value = stored_values[best];
                    r.index = best[nns_pkg::OUT_IDX_W-1:0];
                    r.dsq = best_d;
                    n_found++;
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        return r;
    endfunction

    task automatic push_beat(
        input logic [1:0]                  func,
        input logic [nns_pkg::COORD_W-1:0] c0,
        input logic [nns_pkg::COORD_W-1:0] c1,
        input logic [nns_pkg::COORD_W-1:0] c2,
        input logic [nns_pkg::VALUE_W-1:0] value
    );
        nn_beat_t b;
        b.func = func;
        b.coord = {c2, c1, c0};
        b.value = value;
        if (gen_burst > 0) begin
            gen_burst--;
            b.gap = 0;
        end else if ($urandom_range(0, 29) == 0) begin
            gen_burst = $urandom_range(20, 60);
            b.gap = 0;
        end else begin
            b.gap = $urandom_range(0, MAX_GAP);
        end
        pending_beats.push_back(b);
        if (func != FN_UNUSED) stimulus_beats++;
        if (func == nns_pkg::FN_CLEAR) begin
            gen_count = 0;
        end else if (func == nns_pkg::FN_APPEND && gen_count < nns_pkg::ENTRIES) begin
            gen_points[gen_count] = b.coord;
            gen_count++;
        end
    endtask

    function automatic logic [nns_pkg::COORD_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 16'h8000;
        if (pick == 1) return 16'h7FFF;
        if (pick == 2) return 16'hFFFF;
        if (pick < 8) return nns_pkg::COORD_W'($urandom_range(0, 12) - 6);
        return nns_pkg::COORD_W'($urandom);
    endfunction

    function automatic logic [nns_pkg::COORD_W-1:0] nudge(
        input logic [nns_pkg::COORD_W-1:0] c
    );
        return c + nns_pkg::COORD_W'($urandom_range(0, 6) - 3);
    endfunction

    task automatic push_append();
        logic [2:0][nns_pkg::COORD_W-1:0] p;
        if (gen_count > 0 && $urandom_range(0, 3) == 0) begin
            p = gen_points[$urandom_range(0, gen_count - 1)];
        end else begin
            p = {random_coord(), random_coord(), random_coord()};
        end
        push_beat(nns_pkg::FN_APPEND, p[0], p[1], p[2], $urandom);
    endtask

    task automatic push_query();
        logic [2:0][nns_pkg::COORD_W-1:0] p;
        int pick;
        pick = $urandom_range(0, 2);
        if (gen_count > 0 && pick == 0) begin
            p = gen_points[$urandom_range(0, gen_count - 1)];
        end else if (gen_count > 0 && pick == 1) begin
            p = gen_points[$urandom_range(0, gen_count - 1)];
            p = {nudge(p[2]), nudge(p[1]), nudge(p[0])};
        end else begin
            p = {random_coord(), random_coord(), random_coord()};
        end
        push_beat(nns_pkg::FN_QUERY, p[0], p[1], p[2], $urandom);
    endtask

    task automatic build_stimulus();
        int kind;
        int seq;
        push_beat(nns_pkg::FN_QUERY, 16'd0, 16'd0, 16'd0, 32'h1234_5678);
        push_beat(FN_UNUSED, 16'h7FFF, 16'h8000, 16'h0001, 32'hFFFF_FFFF);
        push_beat(nns_pkg::FN_APPEND, 16'h8000, 16'h8000, 16'h8000, 32'h0000_0000);
        push_beat(nns_pkg::FN_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0000);
        push_beat(nns_pkg::FN_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        push_beat(nns_pkg::FN_QUERY, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
        push_beat(nns_pkg::FN_APPEND, 16'h8000, 16'h8000, 16'h8000, 32'h5555_AAAA);
        push_beat(nns_pkg::FN_QUERY, 16'h8000, 16'h8000, 16'h8000, 32'h0);
        push_beat(nns_pkg::FN_APPEND, 16'd100, 16'd200, 16'd300, 32'h0000_0001);
        push_beat(nns_pkg::FN_APPEND, 16'd100, 16'd200, 16'd300, 32'h0000_0002);
        push_beat(nns_pkg::FN_APPEND, 16'd100, 16'd200, 16'd300, 32'h0000_0003);
        push_beat(nns_pkg::FN_QUERY, 16'd100, 16'd200, 16'd300, 32'h0);
        push_beat(nns_pkg::FN_QUERY, 16'd101, 16'd200, 16'd300, 32'h0);
        push_beat(FN_UNUSED, 16'd100, 16'd200, 16'd300, 32'hAAAA_5555);
        push_beat(nns_pkg::FN_QUERY, 16'h0000, 16'hFFFF, 16'h0001, 32'h0);
        push_beat(nns_pkg::FN_CLEAR, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        push_beat(nns_pkg::FN_QUERY, 16'd100, 16'd200, 16'd300, 32'h0);
        push_beat(nns_pkg::FN_APPEND, 16'hFFFF, 16'h0000, 16'h7FFF, 32'hA5A5_A5A5);
        push_beat(nns_pkg::FN_QUERY, 16'd0, 16'd0, 16'd0, 32'h0);
        push_beat(nns_pkg::FN_CLEAR, 16'd0, 16'd0, 16'd0, 32'h0);
        stimulus_beats = 0;
        seq = 0;
        while (stimulus_beats < RANDOM_BEATS) begin
            kind = (seq == 0) ? 0 : $urandom_range(1, 100);
            if (kind < 4) begin
                while (gen_count < nns_pkg::ENTRIES) push_append();
                repeat ($urandom_range(1, 3)) push_append();
                repeat ($urandom_range(2, 5)) push_query();
            end else if (kind < 86) begin
                if (gen_count > 0 && $urandom_range(0, 2) == 0)
                    push_beat(nns_pkg::FN_CLEAR, random_coord(), random_coord(),
                              random_coord(), $urandom);
                repeat ($urandom_range(1, 6)) push_append();
                repeat ($urandom_range(1, 5)) push_query();
            end else begin
                repeat ($urandom_range(1, 4))
                    push_beat(2'($urandom_range(0, 3)), random_coord(), random_coord(),
                              random_coord(), $urandom);
            end
            seq++;
        end
        total_beats = pending_beats.size();
    endtask

    // Driver: the gap of each beat is waited out before the beat is offered.
    nn_beat_t current_beat;
    int       gap_waited = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_waited = 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(search_nearest(current_beat));
                beats_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_waited < pending_beats[0].gap) begin
                    gap_waited++;
                    s_valid <= 1'b0;
                end else begin
                    current_beat = pending_beats.pop_front();
                    gap_waited = 0;
                    s_func <= current_beat.func;
                    s_coord0 <= current_beat.coord[0];
                    s_coord1 <= current_beat.coord[1];
                    s_coord2 <= current_beat.coord[2];
                    s_entry_value <= current_beat.value;
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor and receiver: each result beat is checked, then a stall is drawn.
    nn_result_t want;
    int         stall_left = 0;
    int         fast_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result beat with no prediction: %0h %0h %0h %0h",
                                           m_status, m_found_value, m_found_index,
                                           m_distance_sq));
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_error($sformatf("result %0d status %0h, predicted %0h",
                                               results_checked, m_status, want.status));
                    if (m_found_value !== want.value)
                        report_error($sformatf("result %0d found_value %0h, predicted %0h",
                                               results_checked, m_found_value, want.value));
                    if (m_found_index !== want.index)
                        report_error($sformatf("result %0d found_index %0d, predicted %0d",
                                               results_checked, m_found_index, want.index));
                    if (m_distance_sq !== want.dsq)
                        report_error($sformatf("result %0d distance_sq %0h, predicted %0h",
                                               results_checked, m_distance_sq, want.dsq));
                end
                results_checked++;
                if (fast_left > 0) begin
                    fast_left--;
                    stall_left = 0;
                end else if ($urandom_range(0, 29) == 0) begin
                    fast_left = $urandom_range(20, 60);
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, MAX_GAP);
                end
            end
            if (hold_off || stall_left > 0) begin
                if (stall_left > 0) stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // A long receiver stall lets the block back up onto its input.
    initial begin
        while (results_checked < 300) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        build_stimulus();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (beats_accepted < total_beats) @(posedge aclk);
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d beats: %0d appends, %0d to a full table, %0d clears, %0d unused.",
                 beats_accepted, n_appends, n_full, n_clears, n_unused);
        $display("%0d queries found a neighbor (%0d later exact matches), %0d on an empty table.",
                 n_found, n_later_zero, n_empty);
        if (failures == 0) begin
            $display("tb_nearest_neighbor_search OK");
        end else begin
            $display("tb_nearest_neighbor_search NOT OK");
        end
        $finish;
    end

endmodule
